/* design/i2cm_pkg.sv */
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types and constants for the I2C register access master.
// ----------------------------------------------------------------------------
package i2cm_pkg;

   typedef enum logic [13:0] {
      PH_IDLE       = 14'b00000000000001,
      PH_BUS_CHECK  = 14'b00000000000010,
      PH_START_HOLD = 14'b00000000000100,
      PH_WR_LOW     = 14'b00000000001000,
      PH_WR_HIGH    = 14'b00000000010000,
      PH_ACK_POLL   = 14'b00000000100000,
      PH_ACK_HIGH   = 14'b00000001000000,
      PH_RD_LOW     = 14'b00000010000000,
      PH_RD_HIGH    = 14'b00000100000000,
      PH_RS_LOW     = 14'b00001000000000,
      PH_STOP_POLL  = 14'b00010000000000,
      PH_STOP_SETUP = 14'b00100000000000,
      PH_STOP_HIGH  = 14'b01000000000000,
      PH_BUS_FREE   = 14'b10000000000000
   } phase_type;

   typedef enum logic [1:0] {
      OP_WRITE  = 2'd0,
      OP_READ   = 2'd1,
      OP_RSTART = 2'd2,
      OP_STOP   = 2'd3
   } op_type;

   localparam logic [1:0] KIND_WRITE  = 2'd0;
   localparam logic [1:0] KIND_READ   = 2'd1;
   localparam logic [1:0] KIND_RSTART = 2'd2;

   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_BUS_BUSY   = 3'd1;
   localparam logic [2:0] ST_SCL_STUCK  = 3'd2;
   localparam logic [2:0] ST_MISMATCH   = 3'd3;
   localparam logic [2:0] ST_NO_ACK     = 3'd4;
   localparam logic [2:0] ST_SDA_STUCK  = 3'd5;

   localparam logic [2:0] CSR_PULL_UP    = 3'd0;
   localparam logic [2:0] CSR_ACK_OFF    = 3'd1;
   localparam logic [2:0] CSR_SCL_LOW    = 3'd2;
   localparam logic [2:0] CSR_SCL_HIGH   = 3'd3;
   localparam logic [2:0] CSR_BUS_FREE   = 3'd4;
   localparam logic [2:0] CSR_BUS_WAIT   = 3'd5;
   localparam logic [2:0] CSR_BUS_RETRY  = 3'd6;
   localparam logic [2:0] CSR_ACK_RETRY  = 3'd7;

   typedef struct packed {
      logic       ack_check_off;
      logic [7:0] scl_low_ticks;
      logic [7:0] scl_high_ticks;
      logic [7:0] bus_free_ticks;
      logic [7:0] bus_wait_ticks;
      logic [3:0] max_bus_retries;
      logic [3:0] max_ack_retries;
   } cfg_type;

   typedef struct packed {
      logic       sda_drive_low;
      logic       scl_drive_low;
      logic       busy_res;
      logic       done_res;
      logic [2:0] status;
      logic [7:0] rd_data;
   } rsp_type;

   function automatic logic [7:0] at_least_one(input logic [7:0] v);
      return (v == 8'd0) ? 8'd1 : v;
   endfunction

endpackage

/* design/i2cm_csr.sv */
// ----------------------------------------------------------------------------
// i2cm_csr
// Configuration register file for the I2C register access master.
// ----------------------------------------------------------------------------
module i2cm_csr
   import i2cm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic [2:0] csr_index,
   input  logic [7:0] csr_wr_data,
   output cfg_type    cfg
);

   cfg_type cfg_ff, cfg_in;
   logic    pull_up_ff, pull_up_in;

   always_comb begin
      cfg_in     = cfg_ff;
      pull_up_in = pull_up_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_PULL_UP:   pull_up_in             = csr_wr_data[0];
            CSR_ACK_OFF:   cfg_in.ack_check_off   = csr_wr_data[0];
            CSR_SCL_LOW:   cfg_in.scl_low_ticks   = csr_wr_data;
            CSR_SCL_HIGH:  cfg_in.scl_high_ticks  = csr_wr_data;
            CSR_BUS_FREE:  cfg_in.bus_free_ticks  = csr_wr_data;
            CSR_BUS_WAIT:  cfg_in.bus_wait_ticks  = csr_wr_data;
            CSR_BUS_RETRY: cfg_in.max_bus_retries = csr_wr_data[3:0];
            CSR_ACK_RETRY: cfg_in.max_ack_retries = csr_wr_data[3:0];
            default:       cfg_in                 = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pull_up_ff             <= 1'b0;
         cfg_ff.ack_check_off   <= 1'b0;
         cfg_ff.scl_low_ticks   <= 8'd2;
         cfg_ff.scl_high_ticks  <= 8'd1;
         cfg_ff.bus_free_ticks  <= 8'd2;
         cfg_ff.bus_wait_ticks  <= 8'd10;
         cfg_ff.max_bus_retries <= 4'd10;
         cfg_ff.max_ack_retries <= 4'd10;
      end else begin
         pull_up_ff <= pull_up_in;
         cfg_ff     <= cfg_in;
      end
   end

   // pull-up selection is held in a register but drives no output of this module
   assign cfg = cfg_ff;

endmodule

/* design/i2cm_engine.sv */
// ----------------------------------------------------------------------------
// i2cm_engine
// Bus sequencer: one tick or command per cycle while step is high; result is combinational.
// ----------------------------------------------------------------------------
module i2cm_engine
   import i2cm_pkg::*;
#(
   parameter int STOP_TICKS  = 1,
   parameter int RETRY_TICKS = 1
)
(
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       step,
   input  logic       action,
   input  logic [1:0] cmd_kind,
   input  logic [7:0] dev_addr,
   input  logic [7:0] reg_addr,
   input  logic [7:0] wr_data,
   input  logic       sda_in,
   input  logic       scl_in,
   output rsp_type    rsp
);

   localparam logic [7:0] StopT  = 8'(STOP_TICKS);
   localparam logic [7:0] RetryT = 8'(RETRY_TICKS);

   phase_type  phase_ff, phase_in;
   logic [3:0] bit_ff, bit_in, retry_ff, retry_in;
   logic [2:0] idx_ff, idx_in;
   logic [7:0] timer_ff, timer_in, shift_ff, shift_in, rdb_ff, rdb_in;
   logic [1:0] kind_ff, kind_in;
   logic [7:0] dev_ff, dev_in, reg_ff, reg_in, dat_ff, dat_in;
   logic [2:0] stat_ff, stat_in;
   logic       sda_ff, sda_in_n, scl_ff, scl_in_n, stuck_ff, stuck_in, done_in;

   logic [2:0] bi_idx;
   logic [7:0] bi_low;
   logic       bi_go;
   op_type     op;
   logic [7:0] op_byte;
   logic [3:0] bit_inc;
   logic [7:0] shl;

   always_comb begin
      op      = OP_STOP;
      op_byte = 8'd0;
      if (bi_idx == 3'd0) begin
         op      = OP_WRITE;
         op_byte = (kind_ff == KIND_RSTART) ? {dev_ff[7:1], 1'b0} : dev_ff;
      end else if (bi_idx == 3'd1) begin
         op      = OP_WRITE;
         op_byte = reg_ff;
      end else if (kind_ff == KIND_WRITE) begin
         if (bi_idx == 3'd2) begin
            op      = OP_WRITE;
            op_byte = dat_ff;
         end
      end else if (kind_ff == KIND_READ) begin
         if (bi_idx == 3'd2) op = OP_READ;
      end else begin
         if (bi_idx == 3'd2) op = OP_RSTART;
         else if (bi_idx == 3'd3) begin
            op      = OP_WRITE;
            op_byte = {dev_ff[7:1], 1'b1};
         end else if (bi_idx == 3'd4) op = OP_READ;
      end
   end

   always_comb begin
      phase_in = phase_ff; bit_in = bit_ff; retry_in = retry_ff; idx_in = idx_ff;
      timer_in = timer_ff; shift_in = shift_ff; rdb_in = rdb_ff; kind_in = kind_ff;
      dev_in = dev_ff; reg_in = reg_ff; dat_in = dat_ff; stat_in = stat_ff;
      sda_in_n = sda_ff; scl_in_n = scl_ff; stuck_in = stuck_ff; done_in = 1'b0;
      bi_go = 1'b0; bi_idx = idx_ff; bi_low = cfg.scl_low_ticks;
      bit_inc = bit_ff + 4'd1;
      shl = {shift_ff[6:0], 1'b0};
      if (action) begin
         if (phase_ff == PH_IDLE && cmd_kind != 2'd3) begin
            kind_in = cmd_kind; dev_in = dev_addr; reg_in = reg_addr; dat_in = wr_data;
            idx_in = 3'd0; bit_in = 4'd0; retry_in = 4'd0; stuck_in = 1'b0;
            sda_in_n = 1'b0; scl_in_n = 1'b0;
            phase_in = PH_BUS_CHECK; timer_in = 8'd1;
         end
      end else if (phase_ff != PH_IDLE) begin
         if (timer_ff > 8'd1) begin
            timer_in = timer_ff - 8'd1;
         end else begin
            timer_in = 8'd0;
            case (phase_ff)
               PH_BUS_CHECK: begin
                  if (sda_in && scl_in) begin
                     sda_in_n = 1'b1; retry_in = 4'd0;
                     phase_in = PH_START_HOLD; timer_in = at_least_one(cfg.scl_low_ticks);
                  end else if (retry_ff >= cfg.max_bus_retries) begin
                     phase_in = PH_IDLE; stat_in = ST_BUS_BUSY; done_in = 1'b1;
                  end else begin
                     retry_in = retry_ff + 4'd1;
                     timer_in = at_least_one(cfg.bus_wait_ticks);
                  end
               end
               PH_START_HOLD: begin
                  if (scl_in) begin
                     scl_in_n = 1'b1; bi_go = 1'b1;
                     bi_low = at_least_one({1'b0, cfg.scl_low_ticks[7:1]});
                  end else if (retry_ff >= cfg.max_bus_retries) begin
                     phase_in = PH_IDLE; stat_in = ST_SCL_STUCK; done_in = 1'b1;
                  end else begin
                     retry_in = retry_ff + 4'd1;
                     timer_in = at_least_one(cfg.bus_wait_ticks);
                  end
               end
               PH_WR_LOW: begin
                  if (shift_ff[7] && !sda_in) begin
                     phase_in = PH_IDLE; stat_in = ST_MISMATCH; done_in = 1'b1;
                  end else begin
                     scl_in_n = 1'b0; phase_in = PH_WR_HIGH;
                     timer_in = at_least_one(cfg.scl_high_ticks);
                  end
               end
               PH_WR_HIGH: begin
                  scl_in_n = 1'b1; shift_in = shl; bit_in = bit_inc;
                  timer_in = at_least_one(cfg.scl_low_ticks);
                  if (bit_inc < 4'd8) begin
                     sda_in_n = ~shl[7]; phase_in = PH_WR_LOW;
                  end else begin
                     sda_in_n = 1'b0; retry_in = 4'd0; phase_in = PH_ACK_POLL;
                  end
               end
               PH_ACK_POLL: begin
                  if (cfg.ack_check_off || !sda_in) begin
                     scl_in_n = 1'b0; phase_in = PH_ACK_HIGH;
                     timer_in = at_least_one(cfg.scl_high_ticks);
                  end else if (retry_ff >= cfg.max_ack_retries) begin
                     phase_in = PH_IDLE; stat_in = ST_NO_ACK; done_in = 1'b1;
                  end else begin
                     retry_in = retry_ff + 4'd1; timer_in = at_least_one(RetryT);
                  end
               end
               PH_ACK_HIGH: begin
                  scl_in_n = 1'b1; bi_idx = idx_ff + 3'd1; bi_go = 1'b1;
               end
               PH_RD_LOW: begin
                  scl_in_n = 1'b0; phase_in = PH_RD_HIGH;
                  timer_in = at_least_one(cfg.scl_high_ticks);
               end
               PH_RD_HIGH: begin
                  shift_in = {shift_ff[6:0], sda_in}; scl_in_n = 1'b1; bit_in = bit_inc;
                  if (bit_inc < 4'd8) begin
                     phase_in = PH_RD_LOW; timer_in = at_least_one(cfg.scl_low_ticks);
                  end else begin
                     rdb_in = {shift_ff[6:0], sda_in};
                     bi_idx = idx_ff + 3'd1; bi_go = 1'b1;
                  end
               end
               PH_RS_LOW: begin
                  scl_in_n = 1'b0; sda_in_n = 1'b0; retry_in = 4'd0;
                  phase_in = PH_BUS_CHECK; timer_in = at_least_one(cfg.bus_wait_ticks);
               end
               PH_STOP_POLL: begin
                  if (sda_in || retry_ff >= cfg.max_ack_retries) begin
                     if (!sda_in) stuck_in = 1'b1;
                     sda_in_n = 1'b1; phase_in = PH_STOP_SETUP; timer_in = 8'd1;
                  end else begin
                     retry_in = retry_ff + 4'd1; timer_in = at_least_one(RetryT);
                  end
               end
               PH_STOP_SETUP: begin
                  scl_in_n = 1'b0; phase_in = PH_STOP_HIGH; timer_in = at_least_one(StopT);
               end
               PH_STOP_HIGH: begin
                  sda_in_n = 1'b0; phase_in = PH_BUS_FREE;
                  timer_in = at_least_one(cfg.bus_free_ticks);
               end
               default: begin
                  phase_in = PH_IDLE; done_in = 1'b1;
                  stat_in = stuck_ff ? ST_SDA_STUCK : ST_OK;
               end
            endcase
            if (done_in) begin
               sda_in_n = 1'b0; scl_in_n = 1'b0; timer_in = 8'd0;
            end
            if (bi_go) begin
               idx_in = bi_idx; bit_in = 4'd0; retry_in = 4'd0;
               timer_in = at_least_one(bi_low);
               case (op)
                  OP_WRITE: begin
                     shift_in = op_byte; sda_in_n = ~op_byte[7]; phase_in = PH_WR_LOW;
                  end
                  OP_READ: begin
                     sda_in_n = 1'b0; shift_in = 8'd0; phase_in = PH_RD_LOW;
                  end
                  OP_RSTART: begin
                     sda_in_n = 1'b0; idx_in = bi_idx + 3'd1; phase_in = PH_RS_LOW;
                  end
                  default: begin
                     sda_in_n = 1'b0; phase_in = PH_STOP_POLL;
                  end
               endcase
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE; bit_ff <= '0; retry_ff <= '0; idx_ff <= '0;
         timer_ff <= '0; shift_ff <= '0; rdb_ff <= '0; kind_ff <= '0;
         dev_ff <= '0; reg_ff <= '0; dat_ff <= '0; stat_ff <= ST_OK;
         sda_ff <= 1'b0; scl_ff <= 1'b0; stuck_ff <= 1'b0;
      end else if (step) begin
         phase_ff <= phase_in; bit_ff <= bit_in; retry_ff <= retry_in; idx_ff <= idx_in;
         timer_ff <= timer_in; shift_ff <= shift_in; rdb_ff <= rdb_in; kind_ff <= kind_in;
         dev_ff <= dev_in; reg_ff <= reg_in; dat_ff <= dat_in; stat_ff <= stat_in;
         sda_ff <= sda_in_n; scl_ff <= scl_in_n; stuck_ff <= stuck_in;
      end
   end

   assign rsp.sda_drive_low = sda_in_n;
   assign rsp.scl_drive_low = scl_in_n;
   assign rsp.busy_res      = (phase_in != PH_IDLE);
   assign rsp.done_res      = done_in;
   assign rsp.status        = stat_in;
   assign rsp.rd_data       = rdb_in;

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      (step && done_in) |=> (phase_ff == PH_IDLE))
      else $error("done without returning to idle");
   a_idle_released: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_IDLE) |-> (!sda_ff && !scl_ff))
      else $error("line driven while idle");
   a_idle_timer: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_IDLE) |-> (timer_ff == 8'd0))
      else $error("timer running while idle");

endmodule

/* design/i2c_register_access_master_top.sv */
// ----------------------------------------------------------------------------
// i2c_register_access_master_top
// I2C master for one-byte register write, read and combined read transactions.
// ----------------------------------------------------------------------------
// Every request (a microsecond tick with sampled SDA/SCL, or a start command)
// yields one registered response carrying the line drives, busy/done flags,
// status and last read byte; one request is accepted per cycle while the
// skid stage is empty, through the single sequencer update between the
// request and the response register, with a one-entry skid stage so a further
// request is still accepted while a response waits to be taken.
module i2c_register_access_master_top
   import i2cm_pkg::*;
#(
   parameter int STOP_TICKS  = 1,
   parameter int RETRY_TICKS = 1
)
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_action,
   input  logic [1:0] req_cmd_kind,
   input  logic [7:0] req_dev_addr,
   input  logic [7:0] req_reg_addr,
   input  logic [7:0] req_wr_data,
   input  logic       req_sda_in,
   input  logic       req_scl_in,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_sda_drive_low,
   output logic       rsp_scl_drive_low,
   output logic       rsp_busy_res,
   output logic       rsp_done_res,
   output logic [2:0] rsp_status,
   output logic [7:0] rsp_rd_data,
   input  logic       csr_wr_en,
   input  logic [2:0] csr_index,
   input  logic [7:0] csr_wr_data
);

   cfg_type cfg;
   rsp_type eng_rsp, out_ff, out_in, skid_ff, skid_in;
   logic    ov_ff, ov_in, sv_ff, sv_in, step;

   i2cm_csr u_csr (
      .clock, .reset, .csr_wr_en, .csr_index, .csr_wr_data, .cfg
   );

   assign req_ready = !sv_ff;
   assign step      = req_valid && req_ready;

   i2cm_engine #(.STOP_TICKS(STOP_TICKS), .RETRY_TICKS(RETRY_TICKS)) u_engine (
      .clock, .reset, .cfg, .step,
      .action(req_action), .cmd_kind(req_cmd_kind), .dev_addr(req_dev_addr),
      .reg_addr(req_reg_addr), .wr_data(req_wr_data),
      .sda_in(req_sda_in), .scl_in(req_scl_in), .rsp(eng_rsp)
   );

   always_comb begin
      out_in = out_ff; ov_in = ov_ff; skid_in = skid_ff; sv_in = sv_ff;
      if (ov_ff && rsp_ready) begin
         ov_in = sv_ff; out_in = skid_ff; sv_in = 1'b0;
      end
      if (step) begin
         if (ov_in) begin
            sv_in = 1'b1; skid_in = eng_rsp;
         end else begin
            ov_in = 1'b1; out_in = eng_rsp;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ov_ff <= 1'b0;
         sv_ff <= 1'b0;
      end else begin
         ov_ff <= ov_in;
         sv_ff <= sv_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid         = ov_ff;
   assign rsp_sda_drive_low = out_ff.sda_drive_low;
   assign rsp_scl_drive_low = out_ff.scl_drive_low;
   assign rsp_busy_res      = out_ff.busy_res;
   assign rsp_done_res      = out_ff.done_res;
   assign rsp_status        = out_ff.status;
   assign rsp_rd_data       = out_ff.rd_data;

   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      sv_ff |-> ov_ff)
      else $error("skid holds data with output empty");
   a_skid_stalls: assert property (@(posedge clock) disable iff (reset)
      (ov_ff && !rsp_ready && step) |=> sv_ff)
      else $error("response lost on stall");
   a_drain: assert property (@(posedge clock) disable iff (reset)
      (sv_ff && rsp_ready) |=> ov_ff)
      else $error("skid entry dropped");

endmodule
